@@ hdl/obpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Order book price ladder package
// Transaction payload types, status codes and register indexes.
// ----------------------------------------------------------------------------
package obpl_pkg;

	localparam int QTY_W  = 48;
	localparam int CNT_W  = 20;
	localparam int PRICE_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_IS_ASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_PRICE  = 2'd1;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef struct packed {
		logic               action;
		logic [PRICE_W-1:0] price;
		logic [31:0]        quantity;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [QTY_W-1:0]   level_total;
		logic [CNT_W-1:0]   level_orders;
		logic               best_valid;
		logic [PRICE_W-1:0] top_price;
		logic [QTY_W-1:0]   best_total;
	} out_item_t;

endpackage

@@ hdl/obpl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module obpl_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/order_book_price_ladder_unit.sv @@
// ----------------------------------------------------------------------------
// Order book price ladder unit
// One side of an order book: per-level totals and counts, best level tracking.
// ----------------------------------------------------------------------------
// Usage. Each input transaction on in_valid/in_ready adds or removes one order
// at a price; each produces exactly one result transaction on
// out_valid/out_ready carrying the status, the touched level and the best level.
// The configuration port (cfg_we, cfg_index, cfg_data) writes side_is_ask
// (index 0) and base_price (index 1); it should be used only while idle.
// Level totals and counts live in one RAM with a registered read. The
// accepting edge also starts the RAM read, the modify state changes the level
// and writes it back, and the push state loads the output register; no new
// item is taken until the last one has left the push state. A price outside
// the window skips the RAM and goes straight to the push state.
// When a remove empties the best level, a scan walks the RAM one entry per
// cycle away from that end of the ladder before the push state.
// After reset a clearing pass writes zero to every level, one per cycle, and
// no input is taken meanwhile. When the receiver stalls, one more transaction
// is taken and processed, then waits in the result stage, and no further
// input is taken until the result in the output register is taken.
// ----------------------------------------------------------------------------
module order_book_price_ladder_unit #(
	parameter int LEVELS = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  obpl_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output obpl_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [obpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data
);

	localparam int IW = $clog2(LEVELS);
	localparam int QW = obpl_pkg::QTY_W;
	localparam int CW = obpl_pkg::CNT_W;
	localparam logic [IW-1:0] LAST = IW'(LEVELS - 1);
	localparam logic [31:0] LEVELS32 = 32'(LEVELS);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_SCAN, S_PUSH} state_t;

	state_t state_q;
	logic side_q;
	logic [31:0] base_q;
	logic [IW-1:0] clr_q, idx_q, best_q, scan_q, chk_q;
	logic act_q, present_q, issued_q, chk_v_q, chk_last_q;
	logic [31:0] qty_q;
	logic [QW-1:0] bqty_q, res_total_q;
	logic [CW-1:0] res_cnt_q;
	logic [1:0] res_st_q;
	logic out_valid_q;
	obpl_pkg::out_item_t out_q;

	// RAM word: {total, count}
	logic ram_we;
	logic [IW-1:0] ram_wa, ram_ra;
	logic [QW+CW-1:0] ram_wd, ram_rd;
	logic [QW-1:0] rd_qty;
	logic [CW-1:0] rd_cnt;

	obpl_ram #(.WIDTH(QW + CW), .DEPTH(LEVELS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	assign rd_qty = ram_rd[QW+CW-1:CW];
	assign rd_cnt = ram_rd[CW-1:0];

	// Window check on the incoming price, done without wrap.
	logic [32:0] diff;
	logic in_range;
	assign diff = {1'b0, in_data.price} - {1'b0, base_q};
	assign in_range = !diff[32] && (diff[31:0] < LEVELS32);

	assign in_ready = (state_q == S_IDLE);

	// Modify stage arithmetic.
	logic [QW:0] qsum;
	logic [QW-1:0] add_q, rem_q;
	logic [CW-1:0] cnt_dec;
	assign qsum = {1'b0, rd_qty} + {{(QW + 1 - 32){1'b0}}, qty_q};
	assign add_q = qsum[QW] ? {QW{1'b1}} : qsum[QW-1:0];
	assign cnt_dec = rd_cnt - CW'(1);
	assign rem_q = (cnt_dec == '0) ? '0 :
		((rd_qty > {{(QW - 32){1'b0}}, qty_q}) ? rd_qty - {{(QW - 32){1'b0}}, qty_q} : '0);

	logic add_ok, rem_ok, better;
	assign add_ok = (act_q == obpl_pkg::ACT_ADD) && (rd_cnt != {CW{1'b1}});
	assign rem_ok = (act_q == obpl_pkg::ACT_REMOVE) && (rd_cnt != '0);
	assign better = side_q ? (idx_q < best_q) : (idx_q > best_q);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q;
		ram_wd = '0;
		ram_ra = scan_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
			end
			S_IDLE: begin
				ram_ra = diff[IW-1:0];
			end
			S_MOD: begin
				ram_we = add_ok || rem_ok;
				ram_wd = add_ok ? {add_q, rd_cnt + CW'(1)} : {rem_q, cnt_dec};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			side_q      <= 1'b0;
			base_q      <= '0;
			clr_q       <= '0;
			best_q      <= '0;
			present_q   <= 1'b0;
			bqty_q      <= '0;
			out_valid_q <= 1'b0;
			chk_v_q     <= 1'b0;
			issued_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					obpl_pkg::CFG_SIDE_IS_ASK: side_q <= cfg_data[0];
					obpl_pkg::CFG_BASE_PRICE:  base_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// The output register loads from the result stage or empties once taken.
			if (state_q == S_PUSH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q <= in_data.action;
						qty_q <= in_data.quantity;
						idx_q <= diff[IW-1:0];
						res_st_q <= obpl_pkg::ST_RANGE;
						res_total_q <= '0;
						res_cnt_q <= '0;
						state_q <= in_range ? S_MOD : S_PUSH;
					end
				end
				S_MOD: begin
					// Emptying the best level starts a scan for the next one.
					state_q <= (rem_ok && present_q && best_q == idx_q && cnt_dec == '0) ?
						S_SCAN : S_PUSH;
					if (act_q == obpl_pkg::ACT_ADD) begin
						if (!add_ok) begin
							res_st_q <= obpl_pkg::ST_FULL;
							res_total_q <= rd_qty;
							res_cnt_q <= rd_cnt;
						end else begin
							res_st_q <= obpl_pkg::ST_OK;
							res_total_q <= add_q;
							res_cnt_q <= rd_cnt + CW'(1);
							if (!present_q || better) begin
								best_q <= idx_q;
								present_q <= 1'b1;
								bqty_q <= add_q;
							end else if (idx_q == best_q) begin
								bqty_q <= add_q;
							end
						end
					end else if (!rem_ok) begin
						res_st_q <= obpl_pkg::ST_EMPTY;
					end else begin
						res_st_q <= obpl_pkg::ST_OK;
						res_total_q <= rem_q;
						res_cnt_q <= cnt_dec;
						if (present_q && best_q == idx_q) begin
							if (cnt_dec == '0) begin
								scan_q <= side_q ? '0 : LAST;
								issued_q <= 1'b0;
								chk_v_q <= 1'b0;
							end else begin
								bqty_q <= rem_q;
							end
						end
					end
				end
				S_SCAN: begin
					if (chk_v_q && rd_cnt != '0) begin
						best_q <= chk_q;
						present_q <= 1'b1;
						bqty_q <= rd_qty;
						state_q <= S_PUSH;
					end else if (chk_v_q && chk_last_q) begin
						best_q <= '0;
						present_q <= 1'b0;
						bqty_q <= '0;
						state_q <= S_PUSH;
					end else if (!issued_q) begin
						chk_q <= scan_q;
						chk_v_q <= 1'b1;
						chk_last_q <= side_q ? (scan_q == LAST) : (scan_q == '0);
						issued_q <= side_q ? (scan_q == LAST) : (scan_q == '0);
						scan_q <= side_q ? scan_q + IW'(1) : scan_q - IW'(1);
					end else begin
						chk_v_q <= 1'b0;
					end
				end
				S_PUSH: begin
					if (!out_valid_q || out_ready) begin
						out_q.status <= res_st_q;
						out_q.level_total <= res_total_q;
						out_q.level_orders <= res_cnt_q;
						out_q.best_valid <= present_q;
						out_q.top_price <= present_q ?
							base_q + {{(32 - IW){1'b0}}, best_q} : '0;
						out_q.best_total <= present_q ? bqty_q : '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ tb/obpl_ladder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price ladder checker
// Watches the configuration port and both transaction channels of the ladder,
// keeps its own copy of the ladder, predicts every result and compares it.
// ----------------------------------------------------------------------------
module obpl_ladder_checker #(
	parameter int LEVELS = 8192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  obpl_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  obpl_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [obpl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output int                             awaited,
	output int                             errors
);

	localparam logic [obpl_pkg::QTY_W-1:0] QTY_TOP = '1;
	localparam logic [obpl_pkg::CNT_W-1:0] CNT_TOP = '1;

	logic [obpl_pkg::QTY_W-1:0]   book_qty [LEVELS];
	logic [obpl_pkg::CNT_W-1:0]   book_cnt [LEVELS];
	logic [31:0]                  top_idx;
	logic                         top_present;
	logic                         ask_side;
	logic [obpl_pkg::PRICE_W-1:0] base;
	obpl_pkg::out_item_t          results_due[$];

	// Find the new best level after the old one emptied.
	function automatic void find_best();
		top_present = 1'b0;
		top_idx = 0;
		if (ask_side) begin
			for (int i = 0; i < LEVELS; i++)
				if (book_cnt[i] != 0) begin
					top_idx = i;
					top_present = 1'b1;
					return;
				end
		end else begin
			for (int i = LEVELS - 1; i >= 0; i--)
				if (book_cnt[i] != 0) begin
					top_idx = i;
					top_present = 1'b1;
					return;
				end
		end
	endfunction

	function automatic obpl_pkg::out_item_t apply_order(obpl_pkg::in_item_t it);
		obpl_pkg::out_item_t r;
		logic [32:0] off;
		logic [obpl_pkg::QTY_W:0] sum;
		int idx;
		r = '0;
		off = {1'b0, it.price} - {1'b0, base};
		if (it.price < base || off >= LEVELS) begin
			r.status = obpl_pkg::ST_RANGE;
		end else begin
			idx = int'(off);
			if (it.action == obpl_pkg::ACT_ADD) begin
				if (book_cnt[idx] == CNT_TOP) begin
					r.status = obpl_pkg::ST_FULL;
				end else begin
					sum = {1'b0, book_qty[idx]} + it.quantity;
					book_qty[idx] = sum > QTY_TOP ? QTY_TOP : sum[obpl_pkg::QTY_W-1:0];
					book_cnt[idx]++;
					if (!top_present) begin
						top_idx = idx;
						top_present = 1'b1;
					end else if (ask_side ? (idx < top_idx) : (idx > top_idx)) begin
						top_idx = idx;
					end
				end
				r.level_total = book_qty[idx];
				r.level_orders = book_cnt[idx];
			end else if (book_cnt[idx] == 0) begin
				r.status = obpl_pkg::ST_EMPTY;
			end else begin
				book_cnt[idx]--;
				book_qty[idx] = book_qty[idx] > it.quantity ? book_qty[idx] - it.quantity : '0;
				if (book_cnt[idx] == 0) begin
					book_qty[idx] = '0;
					if (top_present && top_idx == idx)
						find_best();
				end
				r.level_total = book_qty[idx];
				r.level_orders = book_cnt[idx];
			end
		end
		if (top_present) begin
			r.best_valid = 1'b1;
			r.top_price = base + top_idx[obpl_pkg::PRICE_W-1:0];
			r.best_total = book_qty[top_idx];
		end
		return r;
	endfunction

	assign awaited = results_due.size();

	always @(posedge clk or negedge arst_n) begin
		obpl_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				book_qty[i] = '0;
				book_cnt[i] = '0;
			end
			top_idx = 0;
			top_present = 1'b0;
			ask_side = 1'b0;
			base = '0;
			results_due.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == obpl_pkg::CFG_SIDE_IS_ASK)
					ask_side = cfg_data[0];
				else if (cfg_index == obpl_pkg::CFG_BASE_PRICE)
					base = cfg_data;
			end
			if (in_valid && in_ready)
				results_due.insert(results_due.size(), apply_order(in_data));
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					want = results_due.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						errors++;
					end
					if (out_data.level_total !== want.level_total) begin
						$error("level_total: expected %0d, got %0d",
							want.level_total, out_data.level_total);
						errors++;
					end
					if (out_data.level_orders !== want.level_orders) begin
						$error("level_orders: expected %0d, got %0d",
							want.level_orders, out_data.level_orders);
						errors++;
					end
					if (out_data.best_valid !== want.best_valid) begin
						$error("best_valid: expected %0d, got %0d",
							want.best_valid, out_data.best_valid);
						errors++;
					end
					if (out_data.top_price !== want.top_price) begin
						$error("top_price: expected %0d, got %0d",
							want.top_price, out_data.top_price);
						errors++;
					end
					if (out_data.best_total !== want.best_total) begin
						$error("best_total: expected %0d, got %0d",
							want.best_total, out_data.best_total);
						errors++;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price ladder testbench
// Drives order transactions through the ladder under several side and base
// settings, with random gaps on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LEVELS = 8192;
	// The clearing pass, a full rescan and the long receiver stall all fit well
	// within this many quiet cycles.
	localparam int QUIET_LIMIT = 60000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	obpl_pkg::in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	obpl_pkg::out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic [obpl_pkg::CFG_IDX_W-1:0] cfg_index = obpl_pkg::CFG_SIDE_IS_ASK;
	logic [31:0] cfg_data = '0;
	int         awaited;
	int         errors;
	int         quiet_cycles = 0;
	logic       steady = 1'b0;   // no idling on either side while set
	logic       hold_req = 1'b0; // asks the receiver for one long stall
	logic [obpl_pkg::PRICE_W-1:0] cur_base;

	always #2 clk = ~clk;

	order_book_price_ladder_unit #(.LEVELS(LEVELS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	obpl_ladder_checker #(.LEVELS(LEVELS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.awaited(awaited), .errors(errors)
	);

	// The receiver stalls now and then. When a long stall is requested it
	// keeps ready low, once per request, so that the
	// result stage fills and the block has to refuse new input transactions.
	always @(negedge clk) begin
		int hold_left;
		bit hold_seen;
		if (hold_req && !hold_seen)
			hold_left = 400;
		hold_seen = hold_req;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 18);
		end
	end

	// Any cycle without a transaction on either channel counts as quiet; too
	// many in a row means the block has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [obpl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == obpl_pkg::CFG_BASE_PRICE)
			cur_base = val;
	endtask

	// Offers one transaction and returns at the falling edge after it was taken.
	// Valid stays high into the next offer unless a gap is chosen.
	task automatic offer(logic act, logic [31:0] price, logic [31:0] qty);
		if (!steady)
			while ($urandom_range(0, 99) < 18) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		in_data <= '{action: act, price: price, quantity: qty};
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Wait until every result has come back, with valid low.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaited != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random order: mostly a cluster at either end of the window so adds and
	// removes meet, sometimes anywhere in the window, sometimes outside it.
	task automatic random_order();
		logic [31:0] price;
		logic [31:0] qty;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			price = $urandom();
		else if (pick < 10)
			price = ($urandom_range(0, 1) != 0) ? cur_base - 1 : cur_base + LEVELS;
		else if (pick < 25)
			price = cur_base + $urandom_range(0, LEVELS - 1);
		else
			price = cur_base + $urandom_range(0, 15) + (($urandom_range(0, 1) != 0) ? LEVELS - 16 : 0);
		pick = $urandom_range(0, 9);
		qty = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
			(pick < 5) ? $urandom() : $urandom_range(1, 200);
		offer(($urandom_range(0, 99) < 55) ? obpl_pkg::ACT_ADD : obpl_pkg::ACT_REMOVE,
			price, qty);
	endtask

	initial begin
		cur_base = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: bid side from base zero, the window edges, an empty
		// remove, clamping of the total and rescans down to an empty book.
		write_reg(obpl_pkg::CFG_SIDE_IS_ASK, 32'd0);
		write_reg(obpl_pkg::CFG_BASE_PRICE, 32'd0);
		offer(obpl_pkg::ACT_ADD, 32'd0, 32'd0);
		offer(obpl_pkg::ACT_ADD, LEVELS - 1, 32'hFFFF_FFFF);
		offer(obpl_pkg::ACT_ADD, LEVELS, 32'd7);
		offer(obpl_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd7);
		offer(obpl_pkg::ACT_REMOVE, 32'd5, 32'd1);
		offer(obpl_pkg::ACT_ADD, 32'd100, 32'd10);
		offer(obpl_pkg::ACT_ADD, 32'd100, 32'd5);
		offer(obpl_pkg::ACT_REMOVE, LEVELS - 1, 32'd1);
		offer(obpl_pkg::ACT_REMOVE, 32'd100, 32'd50);
		offer(obpl_pkg::ACT_REMOVE, 32'd100, 32'd0);
		offer(obpl_pkg::ACT_REMOVE, 32'd0, 32'hFFFF_FFFF);
		offer(obpl_pkg::ACT_REMOVE, 32'd0, 32'd1);
		drain();

		// Ask side near the top of the price range, where the window end
		// would wrap past 2^32.
		write_reg(obpl_pkg::CFG_SIDE_IS_ASK, 32'd1);
		write_reg(obpl_pkg::CFG_BASE_PRICE, 32'hFFFF_F000);
		offer(obpl_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd3);
		offer(obpl_pkg::ACT_ADD, 32'hFFFF_F000, 32'd4);
		offer(obpl_pkg::ACT_ADD, 32'h0000_0000, 32'd4);
		offer(obpl_pkg::ACT_ADD, 32'hFFFF_EFFF, 32'd4);
		offer(obpl_pkg::ACT_REMOVE, 32'hFFFF_F000, 32'd4);
		// Flip the side with the book left occupied: the kept best level is
		// only replaced on a later add or rescan.
		drain();
		write_reg(obpl_pkg::CFG_SIDE_IS_ASK, 32'd0);
		offer(obpl_pkg::ACT_ADD, 32'hFFFF_F800, 32'd9);
		offer(obpl_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'd1);
		drain();

		// Several of the largest orders on one level, so that its total grows
		// well past 32 bits.
		write_reg(obpl_pkg::CFG_BASE_PRICE, 32'd1000);
		for (int i = 0; i < 4; i++)
			offer(obpl_pkg::ACT_ADD, 32'd5000, 32'hFFFF_FFFF);
		offer(obpl_pkg::ACT_REMOVE, 32'd5000, 32'd1);
		drain();

		// Random phases over several settings, extremes among them.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(obpl_pkg::CFG_SIDE_IS_ASK, ph % 2);
			write_reg(obpl_pkg::CFG_BASE_PRICE, (ph == 1) ? 32'hFFFF_FFFF :
				(ph == 2) ? 32'hFFFF_F000 : (ph == 3) ? 32'd0 : $urandom());
			for (int n = 0; n < 100; n++) begin
				steady = (ph == 2 && n >= 20 && n < 80);
				if (ph == 0 && n == 30)
					hold_req = 1'b1;
				if (ph == 0 && n == 32)
					hold_req = 1'b0;
				random_order();
			end
			steady = 1'b0;
			// The sender pauses here until every result is back.
			drain();
		end

		repeat (LEVELS + 50) @(negedge clk);
		if (errors == 0 && awaited == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
